// ===== rtl/core/rln_pkg.sv =====
// Shared constants, state encoding and unit status type for the row L2 normalizer.
// No dependencies; every other file in rtl/core but rln_ram refers to it by scoped names.
package rln_pkg;

  localparam int ELEM_W       = 24;  // Q3.20 element and result width
  localparam int LEN_W        = 4;   // row_length register width
  localparam int MAX_COLUMNS  = 8;
  localparam int ROOT_PRESHIFT = 8;  // sum of squares scaled by 2^8 before the root
  localparam int QUOT_SHIFT   = 24;  // element scaled by 2^24 before the divide
  localparam int QUOT_W       = 24;  // quotient bits produced per divide

  localparam logic [LEN_W-1:0]  LEN_RESET = LEN_W'(8);
  localparam logic [ELEM_W-1:0] SCALE_MAX = {1'b0, {(ELEM_W-1){1'b1}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_READ,
    ST_LOAD,
    ST_DIVIDE,
    ST_EMIT
  } rln_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } rln_unit_stat_t;

endpackage

// ===== rtl/core/row_l2_normalizer.sv =====
// Row L2 normalizer top level: row buffer, serial squarer, root and divide sequencing.
// Depends on rln_pkg, rln_ram, rln_sqrt and rln_div.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / element_i) takes one signed Q3.20 word
//   per handshake. Every row_length words (clamped to 1..MaxColumns) close a row.
//   Output channel (out_valid_o / out_stall_i) gives one word per kept element of
//   the row, in arrival order: element / norm in Q3.20, row_end_o on the last one,
//   zero_norm_o on every word of an all-zero row (those words are zero).
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_row_length_i) is always ready.
// Sequencing:
//   Every accepted word first runs the shift-add squarer, which steps through the
//   significant bits of its magnitude; a word that does not close a row is then done.
//   A closing word then runs the bit-serial root, unless the row sums to zero, and
//   each result passes a RAM read, the divider start, 24 divider steps (both skipped
//   for a zero row) and the load into the output register.
//   Only one word is in work at a time; the input is stalled otherwise.
// Reset clears the row count and sum, sets row_length to 8 and empties the output
// register. A stalled output word holds; the sequencer waits with the next result.
module row_l2_normalizer #(
  parameter int MaxColumns = rln_pkg::MAX_COLUMNS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [rln_pkg::ELEM_W-1:0] element_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [rln_pkg::ELEM_W-1:0] scaled_value_o,
  output logic                              row_end_o,
  output logic                              zero_norm_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rln_pkg::LEN_W-1:0]         cfg_row_length_i
);

  localparam int ElemW = rln_pkg::ELEM_W;
  localparam int CntW  = $clog2(MaxColumns + 1);
  localparam int IdxW  = (MaxColumns > 1) ? $clog2(MaxColumns) : 1;
  localparam int SqW   = 2 * ElemW;
  localparam int SumW  = SqW + CntW;
  localparam int RadW  = 2 * ((SumW + rln_pkg::ROOT_PRESHIFT + 1) / 2);
  localparam int RootW = RadW / 2;
  localparam int NumW  = ElemW + rln_pkg::QUOT_SHIFT + 1;
  localparam int QuotW = rln_pkg::QUOT_W;
  localparam int CmpW  = (CntW > rln_pkg::LEN_W) ? CntW : rln_pkg::LEN_W;

  rln_pkg::rln_state_e state_q, state_d;

  logic [rln_pkg::LEN_W-1:0] row_length_q;
  logic [CntW-1:0]           taken_q, idx_q;
  logic [SumW-1:0]           sum_q;
  logic                      end_q, zero_row_q;
  logic [SqW-1:0]            mcand_q;
  logic [ElemW-1:0]          mplier_q;

  logic                      out_valid_q;
  logic [ElemW-1:0]          scaled_q;
  logic                      row_end_q, zero_norm_q;

  logic                      in_accept, out_free;
  logic                      sqrt_start, div_start, emit_load;
  logic [ElemW-1:0]          in_mag, rd_mag, rd_data;
  logic [CntW-1:0]           taken_inc;
  logic [CmpW-1:0]           len_ext, max_ext, eff_len;
  logic                      last_elem;
  logic [RootW-1:0]          root;
  logic [QuotW-1:0]          quot;
  logic [ElemW-1:0]          q_sat, field;
  logic [NumW-1:0]           num;

  rln_pkg::rln_unit_stat_t   sqrt_stat, div_stat;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign in_mag    = element_i[ElemW-1] ? (~element_i + ElemW'(1)) : element_i;
  assign taken_inc = (taken_q < CntW'(MaxColumns)) ? (taken_q + CntW'(1)) : taken_q;

  assign len_ext = CmpW'(row_length_q);
  assign max_ext = CmpW'(MaxColumns);
  always_comb begin
    if (len_ext == '0) begin
      eff_len = CmpW'(1);
    end else if (len_ext > max_ext) begin
      eff_len = max_ext;
    end else begin
      eff_len = len_ext;
    end
  end

  assign last_elem = ((idx_q + CntW'(1)) == taken_q);

  rln_ram #(
    .Width (ElemW),
    .Depth (MaxColumns)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (in_accept && (taken_q < CntW'(MaxColumns))),
    .waddr_i (taken_q[IdxW-1:0]),
    .wdata_i (element_i),
    .raddr_i (idx_q[IdxW-1:0]),
    .rdata_o (rd_data)
  );

  rln_sqrt #(
    .RadW (RadW)
  ) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (RadW'({sum_q, {rln_pkg::ROOT_PRESHIFT{1'b0}}})),
    .root_o     (root),
    .stat_o     (sqrt_stat)
  );

  assign rd_mag = rd_data[ElemW-1] ? (~rd_data + ElemW'(1)) : rd_data;
  assign num    = (NumW'(rd_mag) << rln_pkg::QUOT_SHIFT) + NumW'(root >> 1);

  rln_div #(
    .NumW  (NumW),
    .DenW  (RootW),
    .QuotW (QuotW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (root),
    .quot_o  (quot),
    .stat_o  (div_stat)
  );

  assign q_sat = (ElemW'(quot) > rln_pkg::SCALE_MAX) ? rln_pkg::SCALE_MAX : ElemW'(quot);
  always_comb begin
    if (zero_row_q) begin
      field = '0;
    end else if (rd_data[ElemW-1]) begin
      field = ~q_sat + ElemW'(1);
    end else begin
      field = q_sat;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rln_pkg::ST_IDLE: begin
        if (in_accept) state_d = rln_pkg::ST_SQUARE;
      end
      rln_pkg::ST_SQUARE: begin
        if (mplier_q == '0) begin
          if (!end_q) begin
            state_d = rln_pkg::ST_IDLE;
          end else if (sum_q == '0) begin
            state_d = rln_pkg::ST_READ;
          end else begin
            state_d = rln_pkg::ST_ROOT;
          end
        end
      end
      rln_pkg::ST_ROOT: begin
        if (sqrt_stat.done) state_d = rln_pkg::ST_READ;
      end
      rln_pkg::ST_READ: begin
        state_d = rln_pkg::ST_LOAD;
      end
      rln_pkg::ST_LOAD: begin
        state_d = zero_row_q ? rln_pkg::ST_EMIT : rln_pkg::ST_DIVIDE;
      end
      rln_pkg::ST_DIVIDE: begin
        if (div_stat.done) state_d = rln_pkg::ST_EMIT;
      end
      rln_pkg::ST_EMIT: begin
        if (out_free) state_d = last_elem ? rln_pkg::ST_IDLE : rln_pkg::ST_READ;
      end
      default: state_d = rln_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o = 1'b1;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    emit_load  = 1'b0;
    case (state_q)
      rln_pkg::ST_IDLE:   in_stall_o = 1'b0;
      rln_pkg::ST_SQUARE: sqrt_start = (mplier_q == '0) && end_q && (sum_q != '0);
      rln_pkg::ST_LOAD:   div_start  = !zero_row_q;
      rln_pkg::ST_EMIT:   emit_load  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rln_pkg::ST_IDLE;
      row_length_q <= rln_pkg::LEN_RESET;
      taken_q      <= '0;
      idx_q        <= '0;
      sum_q        <= '0;
      end_q        <= 1'b0;
      zero_row_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        row_length_q <= cfg_row_length_i;
      end
      if (in_accept) begin
        taken_q <= taken_inc;
        end_q   <= (CmpW'(taken_inc) >= eff_len);
      end
      if (state_q == rln_pkg::ST_SQUARE) begin
        if (mplier_q != '0) begin
          if (mplier_q[0]) sum_q <= sum_q + SumW'(mcand_q);
        end else begin
          idx_q      <= '0;
          zero_row_q <= (sum_q == '0);
        end
      end
      if (emit_load) begin
        idx_q <= idx_q + CntW'(1);
        if (last_elem) begin
          taken_q    <= '0;
          sum_q      <= '0;
          zero_row_q <= 1'b0;
        end
      end
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mcand_q  <= SqW'(in_mag);
      mplier_q <= in_mag;
    end else if (state_q == rln_pkg::ST_SQUARE) begin
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
    end
    if (emit_load) begin
      scaled_q    <= field;
      row_end_q   <= last_elem;
      zero_norm_q <= zero_row_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign scaled_value_o = scaled_q;
  assign row_end_o      = row_end_q;
  assign zero_norm_o    = zero_norm_q;

  a_idle_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rln_pkg::ST_IDLE |-> !sqrt_stat.busy && !div_stat.busy)
    else $error("root or divide unit busy while idle");

  a_zero_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_norm_o |-> scaled_value_o == '0)
    else $error("zero-norm word carries nonzero value");

  a_accept_square: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == rln_pkg::ST_SQUARE)
    else $error("accepted word did not enter squarer");

  a_taken_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    taken_q <= CntW'(MaxColumns))
    else $error("row count beyond buffer depth");

endmodule

// ===== rtl/core/rln_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rln_ram #(
  parameter int Width = 24,
  parameter int Depth = 8
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                            wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                            rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/rln_sqrt.sv =====
// Bit-serial floor square root, one root bit per cycle.
// Depends on rln_pkg for the unit status type.
module rln_sqrt #(
  parameter int RadW = 60
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [RadW-1:0]         radicand_i,
  output logic [RadW/2-1:0]       root_o,
  output rln_pkg::rln_unit_stat_t stat_o
);

  localparam int RootW = RadW / 2;
  localparam int CntW  = $clog2(RootW + 1);

  logic [RadW-1:0]  rad_q,  rad_d;
  logic [RootW:0]   rem_q,  rem_d;
  logic [RootW-1:0] root_q, root_d;
  logic [CntW-1:0]  cnt_q,  cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [RootW+2:0] rem_sh, trial, diff;
  logic             fits;

  assign rem_sh = {rem_q, rad_q[RadW-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign diff   = rem_sh - trial;
  assign fits   = (rem_sh >= trial);

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CntW'(RootW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d  = rad_q << 2;
      rem_d  = fits ? diff[RootW:0] : rem_sh[RootW:0];
      root_d = {root_q[RootW-2:0], fits};
      cnt_d  = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o      = root_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ===== rtl/core/rln_div.sv =====
// Restoring divider, one quotient bit per cycle; the quotient must fit in QuotW bits.
// Depends on rln_pkg for the unit status type.
module rln_div #(
  parameter int NumW  = 49,
  parameter int DenW  = 30,
  parameter int QuotW = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [NumW-1:0]         num_i,
  input  logic [DenW-1:0]         den_i,
  output logic [QuotW-1:0]        quot_o,
  output rln_pkg::rln_unit_stat_t stat_o
);

  localparam int CntW = $clog2(QuotW + 1);

  logic [DenW-1:0]  den_q,  den_d;
  logic [DenW-1:0]  rem_q,  rem_d;
  logic [QuotW-1:0] low_q,  low_d;
  logic [QuotW-1:0] quot_q, quot_d;
  logic [CntW-1:0]  cnt_q,  cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [DenW:0]   rem_sh;
  logic [DenW+1:0] diff;
  logic            fits;

  assign rem_sh = {rem_q, low_q[QuotW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
  assign fits   = !diff[DenW+1];

  always_comb begin
    den_d  = den_q;
    rem_d  = rem_q;
    low_d  = low_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      den_d  = den_i;
      rem_d  = DenW'(num_i >> QuotW);
      low_d  = num_i[QuotW-1:0];
      quot_d = '0;
      cnt_d  = CntW'(QuotW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? diff[DenW-1:0] : rem_sh[DenW-1:0];
      low_d  = low_q << 1;
      quot_d = {quot_q[QuotW-2:0], fits};
      cnt_d  = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q  <= den_d;
    rem_q  <= rem_d;
    low_q  <= low_d;
    quot_q <= quot_d;
  end

  assign quot_o      = quot_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench for row_l2_normalizer: predicts every normalized word of each row and checks
// the output stream in order. Depends on rln_pkg and the row_l2_normalizer RTL only.
module tb;

  localparam int IDLE_LIMIT    = 5000;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 600;
  localparam int SEGMENT_WORDS = 30;

  typedef logic signed [rln_pkg::ELEM_W-1:0] elem_t;

  typedef struct packed {
    logic [rln_pkg::ELEM_W-1:0] value;
    logic                       last;
    logic                       zero;
  } norm_word_t;

  typedef enum {ROW_ZERO, ROW_TINY, ROW_CORNER, ROW_WIDE} row_kind_e;

  class row_norm_book;
    elem_t                     kept[rln_pkg::MAX_COLUMNS];
    int unsigned               taken;
    longint unsigned           sq_sum;
    logic [rln_pkg::LEN_W-1:0] length_reg;
    norm_word_t                due[$];
    int                        errors;

    function new();
      taken      = 0;
      sq_sum     = 0;
      length_reg = rln_pkg::LEN_RESET;
      errors     = 0;
    endfunction

    function void set_length(logic [rln_pkg::LEN_W-1:0] len);
      length_reg = len;
    endfunction

    function int unsigned row_size();
      if (length_reg == 0) return 1;
      if (length_reg > rln_pkg::MAX_COLUMNS) return rln_pkg::MAX_COLUMNS;
      return length_reg;
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned res, trial;
      res = 0;
      for (int i = 31; i >= 0; i--) begin
        trial = res | (64'd1 << i);
        if (trial * trial <= v) res = trial;
      end
      return res;
    endfunction

    function void note_element(elem_t v);
      longint signed   e;
      longint unsigned m, r, q;
      bit              zero;
      norm_word_t      w;
      e = v;
      m = (e < 0) ? -e : e;
      if (taken < rln_pkg::MAX_COLUMNS) begin
        kept[taken] = v;
        taken++;
      end
      sq_sum += m * m;
      if (taken < row_size()) return;
      zero = (sq_sum == 0);
      r = zero ? 0 : root_floor(sq_sum << rln_pkg::ROOT_PRESHIFT);
      for (int k = 0; k < taken; k++) begin
        e = kept[k];
        m = (e < 0) ? -e : e;
        q = 0;
        if (!zero && r != 0) begin
          q = ((m << rln_pkg::QUOT_SHIFT) + (r >> 1)) / r;
          if (q > rln_pkg::SCALE_MAX) q = rln_pkg::SCALE_MAX;
        end
        w.value = (e < 0) ? -q[rln_pkg::ELEM_W-1:0] : q[rln_pkg::ELEM_W-1:0];
        w.last  = (k + 1 == taken);
        w.zero  = zero;
        due.push_back(w);
      end
      taken  = 0;
      sq_sum = 0;
    endfunction

    task report(string what);
      $display("[%0t] error: %s", $time, what);
      errors++;
    endtask

    task check_result(elem_t value, logic last, logic zero);
      norm_word_t w;
      if (due.size() == 0) begin
        report($sformatf("unexpected word %0d", value));
      end else begin
        w = due.pop_front();
        if (value !== w.value)
          report($sformatf("scaled_value %0d, predicted %0d", value, $signed(w.value)));
        if (last !== w.last)
          report($sformatf("row_end %b, predicted %b", last, w.last));
        if (zero !== w.zero)
          report($sformatf("zero_norm %b, predicted %b", zero, w.zero));
      end
    endtask
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  elem_t                     element_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  elem_t                     scaled_value_o;
  logic                      row_end_o;
  logic                      zero_norm_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [rln_pkg::LEN_W-1:0] cfg_row_length_i;

  row_norm_book book = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_asks      = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  row_l2_normalizer uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .element_i        (element_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .scaled_value_o   (scaled_value_o),
    .row_end_o        (row_end_o),
    .zero_norm_o      (zero_norm_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_row_length_i (cfg_row_length_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: random stall, or a long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_asks != hold_served) begin
      hold_served = hold_asks;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      book.check_result(scaled_value_o, row_end_o, zero_norm_o);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_element(elem_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    element_i  = v;
    do @(posedge clk_i); while (in_stall_o);
    book.note_element(v);
    @(negedge clk_i);
  endtask

  // wait for the last word plus the time a non-closing word may still take
  task automatic settle();
    in_valid_i = 1'b0;
    while (book.due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_length(logic [rln_pkg::LEN_W-1:0] len);
    cfg_valid_i      = 1'b1;
    cfg_row_length_i = len;
    do @(posedge clk_i); while (!cfg_ready_o);
    book.set_length(len);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic elem_t pick_element(row_kind_e kind);
    int t;
    case (kind)
      ROW_ZERO: return '0;
      ROW_TINY: begin
        t = $urandom_range(31);
        return elem_t'(t - 16);
      end
      ROW_CORNER: begin
        case ($urandom_range(3))
          0:       return 24'sh800000;
          1:       return 24'sh7FFFFF;
          2:       return 24'sh000001;
          default: return 24'shFFFFFF;
        endcase
      end
      default: return ($urandom_range(9) == 0) ? elem_t'(0) : elem_t'($urandom);
    endcase
  endfunction

  task automatic send_row(int n);
    row_kind_e kind;
    case ($urandom_range(9))
      0:       kind = ROW_ZERO;
      1:       kind = ROW_TINY;
      2:       kind = ROW_CORNER;
      default: kind = ROW_WIDE;
    endcase
    repeat (n) send_element(pick_element(kind));
  endtask

  // whole rows at one length; sometimes a partial row is left for the next length
  task automatic run_segment(logic [rln_pkg::LEN_W-1:0] len);
    int sent, size;
    settle();
    write_length(len);
    size = book.row_size();
    sent = 0;
    while (sent < SEGMENT_WORDS) begin
      send_row(size);
      sent += size;
    end
    if (size > 1 && $urandom_range(3) == 0) send_row($urandom_range(size - 1, 1));
  endtask

  initial begin
    elem_t corner_row[8];
    corner_row = '{24'sh800000, 24'sh7FFFFF, 24'sh000000, 24'sh000001,
                   24'shFFFFFF, 24'sh555555, 24'shAAAAAA, 24'sh000100};
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    element_i        = '0;
    cfg_valid_i      = 1'b0;
    cfg_row_length_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct  = 20;
    recv_stall_pct = 70;
    foreach (corner_row[i]) send_element(corner_row[i]);
    settle();
    write_length(4'd1);
    send_element(24'sh000000);
    send_element(24'sh800000);
    send_element(24'sh000001);
    settle();
    write_length(4'd0);
    send_element(24'sh000005);
    settle();
    write_length(4'd15);
    repeat (8) send_element(24'sh000000);
    // shorten the row while three words are kept
    settle();
    write_length(4'd4);
    send_element(24'sh100000);
    send_element(-24'sh100000);
    send_element(24'sh080000);
    settle();
    write_length(4'd2);
    send_element(24'sh040000);

    run_segment(4'd8);
    run_segment(4'd1);
    run_segment(4'($urandom_range(15)));

    send_idle_pct  = 70;
    recv_stall_pct = 20;
    run_segment(4'd15);
    run_segment(4'd0);
    run_segment(4'($urandom_range(15)));

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_asks++;
    run_segment(4'($urandom_range(8, 1)));
    run_segment(4'd9);
    run_segment(4'($urandom_range(15)));

    settle();
    repeat (100) @(negedge clk_i);
    if (book.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
